FILE: hdl/c8080x_pkg.sv
// Package for the 8080 subset execute block: opcodes, flag layout, controller states.
// No dependencies.
`timescale 1ns / 1ps
package c8080x_pkg;

   localparam logic [7:0] OP_NOP     = 8'h00;
   localparam logic [7:0] OP_LXI_B   = 8'h01;
   localparam logic [7:0] OP_DCR_B   = 8'h05;
   localparam logic [7:0] OP_MVI_B   = 8'h06;
   localparam logic [7:0] OP_DAD_B   = 8'h09;
   localparam logic [7:0] OP_DCR_C   = 8'h0D;
   localparam logic [7:0] OP_MVI_C   = 8'h0E;
   localparam logic [7:0] OP_RRC     = 8'h0F;
   localparam logic [7:0] OP_LXI_D   = 8'h11;
   localparam logic [7:0] OP_INX_D   = 8'h13;
   localparam logic [7:0] OP_DAD_D   = 8'h19;
   localparam logic [7:0] OP_LDAX_D  = 8'h1A;
   localparam logic [7:0] OP_MOV_AD  = 8'h7A;
   localparam logic [7:0] OP_CALL    = 8'hCD;
   localparam logic [7:0] OP_POP_D   = 8'hD1;
   localparam logic [7:0] OP_OUT     = 8'hD3;
   localparam logic [7:0] OP_PUSH_D  = 8'hD5;
   localparam logic [7:0] OP_POP_H   = 8'hE1;
   localparam logic [7:0] OP_PUSH_H  = 8'hE5;
   localparam logic [7:0] OP_ANI     = 8'hE6;
   localparam logic [7:0] OP_XCHG    = 8'hEB;
   localparam logic [7:0] OP_POP_PSW = 8'hF1;
   localparam logic [7:0] OP_PUSH_PSW= 8'hF5;
   localparam logic [7:0] OP_EI      = 8'hFB;
   localparam logic [7:0] OP_CPI     = 8'hFE;

   localparam logic KIND_EXEC = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   // flag register bit positions
   localparam int F_C  = 0;
   localparam int F_P  = 1;
   localparam int F_AC = 2;
   localparam int F_Z  = 3;
   localparam int F_S  = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEM1,
      ST_MEM2,
      ST_DONE,
      ST_OUT
   } ctrl_state_type;

   // memory access class of an instruction
   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_PUSH,
      ACC_POP,
      ACC_LDAX
   } access_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the item
      logic mem_op1;   // first memory access
      logic mem_op2;   // second memory access
      logic commit;    // update architectural state
      logic rsp_load;  // load result register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      access_type access;
   } dp_status_type;

   function automatic logic even_parity(input logic [7:0] v);
      return ~(^v);
   endfunction

endpackage

FILE: hdl/c8080x_if.sv
// Valid/ready channel interface carrying one item payload.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
interface c8080x_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/c8080x_ctrl.sv
// Controller state machine: sequences capture, memory accesses, commit, result.
// Depends on c8080x_pkg.
`timescale 1ns / 1ps
module c8080x_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   output logic                      out_valid,
   input  logic                      out_ready,
   input  c8080x_pkg::dp_status_type status,
   output c8080x_pkg::dp_cmd_type    cmd
);
   import c8080x_pkg::*;

   ctrl_state_type state_ff, state_in;

   // advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) state_in = ST_MEM1;
         end
         ST_MEM1: begin
            if (status.access == ACC_NONE) state_in = ST_DONE;
            else state_in = ST_MEM2;
         end
         ST_MEM2: state_in = ST_DONE;
         ST_DONE: state_in = ST_OUT;
         ST_OUT: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.capture = in_valid;
         end
         ST_MEM1: cmd.mem_op1 = 1'b1;
         ST_MEM2: cmd.mem_op2 = 1'b1;
         ST_DONE: begin
            cmd.commit = 1'b1;
            cmd.rsp_load = 1'b1;
         end
         ST_OUT: out_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

FILE: hdl/c8080x_dpath.sv
// Datapath: register file, flags, PC, SP, byte memory and the result register.
// Depends on c8080x_pkg.
`timescale 1ns / 1ps
module c8080x_dpath #(
   parameter int MEM_BYTES = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  c8080x_pkg::dp_cmd_type    cmd,
   output c8080x_pkg::dp_status_type status,
   input  logic                      in_kind,
   input  logic [7:0]                in_opcode,
   input  logic [7:0]                in_low,
   input  logic [7:0]                in_high,
   input  logic [15:0]               in_load_address,
   input  logic [7:0]                in_load_data,
   output logic [15:0]               out_pc,
   output logic [15:0]               out_sp,
   output logic [7:0]                out_a,
   output logic [7:0]                out_b,
   output logic [7:0]                out_c,
   output logic [7:0]                out_d,
   output logic [7:0]                out_e,
   output logic [7:0]                out_h,
   output logic [7:0]                out_l,
   output logic [7:0]                out_status,
   output logic                      out_unimpl,
   output logic [4:0]                out_cost
);
   import c8080x_pkg::*;

   localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
   // reciprocal of the memory size, exact quotient for any 16-bit address
   localparam longint unsigned RECIP = ((64'd1 << 32) / MEM_BYTES) + 64'd1;

   logic [7:0] mem [MEM_BYTES];

   logic        kind_ff;
   logic [7:0]  op_ff, lo_ff, hi_ff, ld_data_ff;
   logic [15:0] ld_addr_ff;

   logic [7:0]  a_ff, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff;
   logic [4:0]  f_ff;
   logic [15:0] pc_ff, sp_ff;
   logic [7:0]  rd_ff;   // registered read data of the first read byte (pop or LDAX)
   logic [7:0]  rd2_ff;  // second read byte

   logic [15:0] pc_rsp_ff, sp_rsp_ff;
   logic [7:0]  a_rsp_ff, b_rsp_ff, c_rsp_ff, d_rsp_ff, e_rsp_ff, h_rsp_ff, l_rsp_ff;
   logic [7:0]  st_rsp_ff;
   logic        un_rsp_ff;
   logic [4:0]  cost_rsp_ff;

   access_type  access;
   logic [7:0]  push_hi, push_lo, psw;
   logic        mem_we;
   logic [15:0] mem_addr;
   logic [7:0]  mem_wdata;
   logic        mem_re;
   logic [AW-1:0] mem_index;

   // reduce an address modulo the memory size by reciprocal multiplication
   function automatic logic [AW-1:0] wrap_addr(input logic [15:0] a);
      logic [47:0] prod;
      logic [15:0] q;
      logic [31:0] rem;
      prod = 48'(a) * 48'(RECIP);
      q    = prod[47:32];
      rem  = 32'(a) - 32'(q) * 32'(MEM_BYTES);
      return rem[AW-1:0];
   endfunction

   // capture the item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= in_kind;
         op_ff      <= in_opcode;
         lo_ff      <= in_low;
         hi_ff      <= in_high;
         ld_addr_ff <= in_load_address;
         ld_data_ff <= in_load_data;
      end
   end

   // pack flags as status byte
   always_comb begin
      psw = {f_ff[F_S], f_ff[F_Z], 1'b1, f_ff[F_AC], 1'b1, f_ff[F_P], 1'b1, f_ff[F_C]};
   end

   // classify memory accesses
   always_comb begin
      access = ACC_NONE;
      push_hi = a_ff;
      push_lo = psw;
      if (kind_ff == KIND_EXEC) begin
         case (op_ff)
            OP_CALL: begin
               access = ACC_PUSH;
               {push_hi, push_lo} = pc_ff + 16'd3;
            end
            OP_PUSH_D: begin
               access = ACC_PUSH; push_hi = d_ff; push_lo = e_ff;
            end
            OP_PUSH_H: begin
               access = ACC_PUSH; push_hi = h_ff; push_lo = l_ff;
            end
            OP_PUSH_PSW: access = ACC_PUSH;
            OP_POP_D, OP_POP_H, OP_POP_PSW: access = ACC_POP;
            OP_LDAX_D: access = ACC_LDAX;
            default: access = ACC_NONE;
         endcase
      end
   end
   assign status.access = access;

   // single memory port: one access per cycle
   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_addr = sp_ff;
      mem_wdata = push_hi;
      if (cmd.mem_op1) begin
         if (kind_ff == KIND_LOAD) begin
            mem_we = 1'b1; mem_addr = ld_addr_ff; mem_wdata = ld_data_ff;
         end else if (access == ACC_PUSH) begin
            mem_we = 1'b1; mem_addr = sp_ff - 16'd1; mem_wdata = push_hi;
         end else if (access == ACC_POP) begin
            mem_re = 1'b1; mem_addr = sp_ff;
         end else if (access == ACC_LDAX) begin
            mem_re = 1'b1; mem_addr = {d_ff, e_ff};
         end
      end else if (cmd.mem_op2) begin
         if (access == ACC_PUSH) begin
            mem_we = 1'b1; mem_addr = sp_ff - 16'd2; mem_wdata = push_lo;
         end else if (access == ACC_POP) begin
            mem_re = 1'b1; mem_addr = sp_ff + 16'd1;
         end
      end
   end

   assign mem_index = wrap_addr(mem_addr);

   // memory array
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_index] <= mem_wdata;
   end
   always_ff @(posedge clock) begin
      if (mem_re && cmd.mem_op1) rd_ff  <= mem[mem_index];
      if (mem_re && cmd.mem_op2) rd2_ff <= mem[mem_index];
   end

   // execute and commit
   logic [7:0]  a_in, b_in, c_in, d_in, e_in, h_in, l_in;
   logic [4:0]  f_in;
   logic [15:0] pc_in, sp_in;
   logic        un_in;
   logic [4:0]  cost_in;
   logic [16:0] dad_sum;
   logic [7:0]  dcr_v, cpi_d;
   logic [4:0]  nib;
   logic [15:0] de_inc;

   always_comb begin
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      h_in = h_ff; l_in = l_ff; f_in = f_ff; pc_in = pc_ff; sp_in = sp_ff;
      un_in = 1'b0; cost_in = 5'd0;
      dad_sum = 17'd0; dcr_v = 8'd0;
      cpi_d = a_ff - lo_ff;
      nib = {1'b0, a_ff[3:0]} + {1'b0, ~lo_ff[3:0]} + 5'd1;
      de_inc = {d_ff, e_ff} + 16'd1;
      if (kind_ff == KIND_EXEC) begin
         case (op_ff)
            OP_NOP, OP_EI: begin pc_in = pc_ff + 16'd1; cost_in = 5'd4; end
            OP_LXI_B: begin b_in = hi_ff; c_in = lo_ff; pc_in = pc_ff + 16'd3; cost_in = 5'd10; end
            OP_LXI_D: begin d_in = hi_ff; e_in = lo_ff; pc_in = pc_ff + 16'd3; cost_in = 5'd10; end
            OP_DCR_B, OP_DCR_C: begin
               if (op_ff == OP_DCR_B) begin
                  f_in[F_AC] = b_ff[3:0] != 4'd0; dcr_v = b_ff - 8'd1; b_in = dcr_v;
               end else begin
                  f_in[F_AC] = c_ff[3:0] != 4'd0; dcr_v = c_ff - 8'd1; c_in = dcr_v;
               end
               f_in[F_S] = dcr_v[7]; f_in[F_Z] = dcr_v == 8'd0;
               f_in[F_P] = even_parity(dcr_v);
               pc_in = pc_ff + 16'd1; cost_in = 5'd5;
            end
            OP_MVI_B: begin b_in = lo_ff; pc_in = pc_ff + 16'd2; cost_in = 5'd7; end
            OP_MVI_C: begin c_in = lo_ff; pc_in = pc_ff + 16'd2; cost_in = 5'd7; end
            OP_DAD_B, OP_DAD_D: begin
               if (op_ff == OP_DAD_B) dad_sum = {1'b0, h_ff, l_ff} + {1'b0, b_ff, c_ff};
               else dad_sum = {1'b0, h_ff, l_ff} + {1'b0, d_ff, e_ff};
               f_in[F_C] = dad_sum[16]; {h_in, l_in} = dad_sum[15:0];
               pc_in = pc_ff + 16'd1; cost_in = 5'd10;
            end
            OP_RRC: begin
               f_in[F_C] = a_ff[0]; a_in = {a_ff[0], a_ff[7:1]};
               pc_in = pc_ff + 16'd1; cost_in = 5'd4;
            end
            OP_INX_D: begin {d_in, e_in} = de_inc; pc_in = pc_ff + 16'd1; cost_in = 5'd5; end
            OP_LDAX_D: begin a_in = rd_ff; pc_in = pc_ff + 16'd1; cost_in = 5'd7; end
            OP_MOV_AD: begin a_in = d_ff; pc_in = pc_ff + 16'd1; cost_in = 5'd5; end
            OP_CALL: begin sp_in = sp_ff - 16'd2; pc_in = {hi_ff, lo_ff}; cost_in = 5'd17; end
            OP_POP_D: begin
               e_in = rd_ff; d_in = rd2_ff; sp_in = sp_ff + 16'd2;
               pc_in = pc_ff + 16'd1; cost_in = 5'd10;
            end
            OP_POP_H: begin
               l_in = rd_ff; h_in = rd2_ff; sp_in = sp_ff + 16'd2;
               pc_in = pc_ff + 16'd1; cost_in = 5'd10;
            end
            OP_POP_PSW: begin
               f_in = {rd_ff[7], rd_ff[6], rd_ff[4], rd_ff[2], rd_ff[0]};
               a_in = rd2_ff; sp_in = sp_ff + 16'd2;
               pc_in = pc_ff + 16'd1; cost_in = 5'd10;
            end
            OP_OUT: begin pc_in = pc_ff + 16'd2; cost_in = 5'd10; end
            OP_PUSH_D, OP_PUSH_H, OP_PUSH_PSW: begin
               sp_in = sp_ff - 16'd2; pc_in = pc_ff + 16'd1; cost_in = 5'd11;
            end
            OP_ANI: begin
               a_in = a_ff & lo_ff;
               f_in[F_C] = 1'b0; f_in[F_AC] = 1'b0;
               f_in[F_S] = a_in[7]; f_in[F_Z] = a_in == 8'd0;
               f_in[F_P] = even_parity(a_in);
               pc_in = pc_ff + 16'd2; cost_in = 5'd7;
            end
            OP_XCHG: begin
               h_in = d_ff; d_in = h_ff; l_in = e_ff; e_in = l_ff;
               pc_in = pc_ff + 16'd1; cost_in = 5'd4;
            end
            OP_CPI: begin
               f_in[F_Z] = a_ff == lo_ff; f_in[F_C] = a_ff < lo_ff;
               f_in[F_AC] = nib[4]; f_in[F_S] = cpi_d[7];
               f_in[F_P] = even_parity(cpi_d);
               pc_in = pc_ff + 16'd2; cost_in = 5'd7;
            end
            default: un_in = 1'b1;
         endcase
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; b_ff <= '0; c_ff <= '0; d_ff <= '0; e_ff <= '0;
         h_ff <= '0; l_ff <= '0; f_ff <= '0; pc_ff <= '0; sp_ff <= '0;
      end else if (cmd.commit) begin
         a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
         h_ff <= h_in; l_ff <= l_in; f_ff <= f_in; pc_ff <= pc_in; sp_ff <= sp_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         pc_rsp_ff <= pc_in; sp_rsp_ff <= sp_in; a_rsp_ff <= a_in;
         b_rsp_ff <= b_in; c_rsp_ff <= c_in; d_rsp_ff <= d_in; e_rsp_ff <= e_in;
         h_rsp_ff <= h_in; l_rsp_ff <= l_in;
         st_rsp_ff <= {f_in[F_S], f_in[F_Z], 1'b1, f_in[F_AC], 1'b1, f_in[F_P], 1'b1, f_in[F_C]};
         un_rsp_ff <= un_in; cost_rsp_ff <= cost_in;
      end
   end

   assign out_pc = pc_rsp_ff;
   assign out_sp = sp_rsp_ff;
   assign out_a = a_rsp_ff;
   assign out_b = b_rsp_ff;
   assign out_c = c_rsp_ff;
   assign out_d = d_rsp_ff;
   assign out_e = e_rsp_ff;
   assign out_h = h_rsp_ff;
   assign out_l = l_rsp_ff;
   assign out_status = st_rsp_ff;
   assign out_unimpl = un_rsp_ff;
   assign out_cost = cost_rsp_ff;
endmodule

FILE: hdl/cpu_8080_subset_execute.sv
// Top level of the 8080 subset execute block: controller plus datapath.
// Depends on c8080x_pkg, c8080x_if, c8080x_ctrl and c8080x_dpath.
//
// Usage: items arrive on req (valid/ready). An item either executes one
// instruction (opcode and up to two operand bytes) or writes one memory byte.
// Each item yields exactly one result on rsp: the full register file, SP, PC,
// packed flags, an unimplemented flag and the instruction's cost as on a real 8080.
// Steps: an item is captured in the accept state (ST_IDLE), then passes through
// ST_MEM1 on the single-port byte memory (and ST_MEM2 for push, pop, CALL and
// LDAX), ST_DONE to commit and load the result register, and ST_OUT, where the
// result is shown. One item at a time: the next item is taken only after the
// result is taken, when the controller is back in ST_IDLE.
// The single memory port and the stack byte pair set the second memory state.
// Reset clears registers, flags, PC and SP to zero; memory content is left
// undefined until written. While rsp is stalled the result holds and req
// stays not ready.
`timescale 1ns / 1ps
module cpu_8080_subset_execute #(
   parameter int MEM_BYTES = 65536
) (
   input  logic clock,
   input  logic reset,
   c8080x_if.sink   req,
   c8080x_if.source rsp
);
   import c8080x_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   c8080x_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   c8080x_dpath #(.MEM_BYTES(MEM_BYTES)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_kind         (req.payload.item_kind),
      .in_opcode       (req.payload.instr_opcode),
      .in_low          (req.payload.operand_low),
      .in_high         (req.payload.operand_high),
      .in_load_address (req.payload.load_address),
      .in_load_data    (req.payload.load_data),
      .out_pc          (rsp.payload.program_counter),
      .out_sp          (rsp.payload.stack_pointer),
      .out_a           (rsp.payload.accumulator),
      .out_b           (rsp.payload.reg_b),
      .out_c           (rsp.payload.reg_c),
      .out_d           (rsp.payload.reg_d),
      .out_e           (rsp.payload.reg_e),
      .out_h           (rsp.payload.reg_h),
      .out_l           (rsp.payload.reg_l),
      .out_status      (rsp.payload.status_word),
      .out_unimpl      (rsp.payload.unimplemented),
      .out_cost        (rsp.payload.cycle_cost)
   );

   // never take an item while a result is pending
   assert property (@(posedge clock) disable iff (reset) !(req.ready && rsp.valid))
      else $error("input ready while result pending");
   // an accepted item does not make the result valid at once
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !rsp.valid)
      else $error("result shown right after accept");
   // a taken result frees the input next cycle
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready) |=> req.ready)
      else $error("input not ready after result taken");
endmodule
